// ===== design/rrtr_pkg.sv =====
// ----------------------------------------------------------------------------
// rrtr_pkg
// Shared sizes, codes and item types of the round-robin thread ring.
// ----------------------------------------------------------------------------
package rrtr_pkg;

   // ring size and id width
   localparam int SLOTS    = 16;
   localparam int ID_WIDTH = 8;

   // derived widths
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   // request codes
   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_GET    = 2'd1,
      OP_RETURN = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NONE      = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_DUP       = 3'd4
   } status_type;

   // input item
   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] thread_id;
   } req_item_type;

   // result item
   typedef struct packed {
      logic [2:0] status;
      logic [7:0] granted_id;
      logic [4:0] occupied_count;
      logic [4:0] free_count;
   } rsp_item_type;

   // ring links of one slot
   typedef struct packed {
      logic [IDX_W-1:0] link_next;
      logic [IDX_W-1:0] link_prev;
   } link_type;

endpackage

// ===== design/rrtr_ram.sv =====
// ----------------------------------------------------------------------------
// rrtr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rrtr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/round_robin_thread_ring.sv =====
// ----------------------------------------------------------------------------
// round_robin_thread_ring
// Ring of thread ids with taken marks and a rotating current pointer.
// Ids and ring links live in two RAMs; valid and taken marks in flip-flops.
// ----------------------------------------------------------------------------
// one item at a time; by request code:
//   get next goes straight to the result on an empty ring, else walks one ring
//   entry per cycle; add on a full ring also goes straight to the result;
//   return, remove and add run the id search, one slot of the id RAM per cycle
// next item accepted the cycle after the result loads; it may wait in the
// result register; reset clears marks, counts and pointer, RAMs need no clearing
module round_robin_thread_ring (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rrtr_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rrtr_pkg::rsp_item_type rsp_item
);

   localparam int IDX_W = rrtr_pkg::IDX_W;
   localparam int CNT_W = rrtr_pkg::CNT_W;
   localparam int ID_W  = rrtr_pkg::ID_WIDTH;
   localparam int SLOTS = rrtr_pkg::SLOTS;
   localparam int LNK_W = $bits(rrtr_pkg::link_type);

   typedef enum logic [14:0] {
      S_IDLE     = 15'b000000000000001,
      S_SCAN     = 15'b000000000000010,
      S_GET_RD   = 15'b000000000000100,
      S_GET_STEP = 15'b000000000001000,
      S_ADD_RD   = 15'b000000000010000,
      S_ADD_P    = 15'b000000000100000,
      S_ADD_WS   = 15'b000000001000000,
      S_ADD_WP   = 15'b000000010000000,
      S_ADD_WC   = 15'b000000100000000,
      S_REM_RD   = 15'b000001000000000,
      S_REM_PV   = 15'b000010000000000,
      S_REM_NX   = 15'b000100000000000,
      S_REM_WP   = 15'b001000000000000,
      S_REM_WN   = 15'b010000000000000,
      S_RESP     = 15'b100000000000000
   } state_type;

   // control state
   state_type              state_ff, state_in;
   logic [SLOTS-1:0]       valid_ff, valid_in;
   logic [SLOTS-1:0]       taken_ff, taken_in;
   logic [IDX_W-1:0]       cur_ff, cur_in;
   logic [CNT_W-1:0]       held_ff, held_in;
   logic [CNT_W-1:0]       untaken_ff, untaken_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // working registers of the item in flight
   logic [1:0]             type_ff, type_in;
   logic [ID_W-1:0]        id_ff, id_in;
   logic [IDX_W-1:0]       slot_ff, slot_in;
   logic [CNT_W-1:0]       scan_ff, scan_in;
   logic                   chk_ff, chk_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   free_seen_ff, free_seen_in;
   logic [IDX_W-1:0]       free_ff, free_in;
   logic [IDX_W-1:0]       walk_ff, walk_in;
   logic [CNT_W-1:0]       step_ff, step_in;
   rrtr_pkg::link_type     lnk_a_ff, lnk_a_in;
   rrtr_pkg::link_type     lnk_b_ff, lnk_b_in;
   rrtr_pkg::link_type     lnk_c_ff, lnk_c_in;
   rrtr_pkg::status_type   status_ff, status_in;
   logic [7:0]             granted_ff, granted_in;
   rrtr_pkg::rsp_item_type rsp_item_ff, rsp_item_in;
   logic                   rsp_load;

   // memory ports
   logic                   id_we;
   logic [IDX_W-1:0]       id_waddr, id_raddr;
   logic [ID_W-1:0]        id_wdata, id_rdata;
   logic                   lnk_we;
   logic [IDX_W-1:0]       lnk_waddr, lnk_raddr;
   rrtr_pkg::link_type     lnk_wdata, lnk_rdata;
   logic [LNK_W-1:0]       lnk_rd_raw;

   // search results
   logic                   scan_hit, scan_done, free_any;
   logic [IDX_W-1:0]       free_now;

   rrtr_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_id_ram (
      .clock   (clock),
      .wr_en   (id_we),
      .wr_addr (id_waddr),
      .wr_data (id_wdata),
      .rd_addr (id_raddr),
      .rd_data (id_rdata)
   );

   rrtr_ram #(.WIDTH(LNK_W), .DEPTH(SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (lnk_we),
      .wr_addr (lnk_waddr),
      .wr_data (lnk_wdata),
      .rd_addr (lnk_raddr),
      .rd_data (lnk_rd_raw)
   );

   assign lnk_rdata = lnk_rd_raw;

   // id search: compare the slot read in the previous cycle
   assign scan_hit  = chk_ff && valid_ff[idx_ff] && (id_rdata == id_ff);
   assign scan_done = chk_ff && (scan_hit || (idx_ff == IDX_W'(SLOTS - 1)));
   assign free_any  = free_seen_ff || (chk_ff && !valid_ff[idx_ff]);
   assign free_now  = free_seen_ff ? free_ff : idx_ff;

   assign req_ready = (state_ff == S_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      taken_in     = taken_ff;
      cur_in       = cur_ff;
      held_in      = held_ff;
      untaken_in   = untaken_ff;
      type_in      = type_ff;
      id_in        = id_ff;
      slot_in      = slot_ff;
      scan_in      = scan_ff;
      chk_in       = chk_ff;
      idx_in       = idx_ff;
      free_seen_in = free_seen_ff;
      free_in      = free_ff;
      walk_in      = walk_ff;
      step_in      = step_ff;
      lnk_a_in     = lnk_a_ff;
      lnk_b_in     = lnk_b_ff;
      lnk_c_in     = lnk_c_ff;
      status_in    = status_ff;
      granted_in   = granted_ff;
      rsp_load     = 1'b0;
      id_we        = 1'b0;
      id_waddr     = slot_ff;
      id_wdata     = id_ff;
      id_raddr     = walk_ff;
      lnk_we       = 1'b0;
      lnk_waddr    = slot_ff;
      lnk_wdata    = lnk_a_ff;
      lnk_raddr    = walk_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               type_in      = req_item.req_type;
               id_in        = ID_W'(req_item.thread_id);
               scan_in      = '0;
               chk_in       = 1'b0;
               free_seen_in = 1'b0;
               walk_in      = cur_ff;
               step_in      = '0;
               granted_in   = '0;
               status_in    = rrtr_pkg::ST_OK;
               if (req_item.req_type == rrtr_pkg::OP_GET) begin
                  if (held_ff == '0) begin
                     status_in = rrtr_pkg::ST_NONE;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_GET_RD;
                  end
               end else if (req_item.req_type == rrtr_pkg::OP_ADD &&
                            held_ff >= CNT_W'(SLOTS)) begin
                  status_in = rrtr_pkg::ST_FULL;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         // one slot of the id RAM per cycle, compared in the next cycle
         S_SCAN: begin
            id_raddr = scan_ff[IDX_W-1:0];
            chk_in   = (scan_ff < CNT_W'(SLOTS));
            idx_in   = scan_ff[IDX_W-1:0];
            if (scan_ff < CNT_W'(SLOTS)) begin
               scan_in = scan_ff + CNT_W'(1);
            end
            if (chk_ff && !valid_ff[idx_ff] && !free_seen_ff) begin
               free_seen_in = 1'b1;
               free_in      = idx_ff;
            end
            if (scan_done) begin
               state_in = S_RESP;
               case (type_ff)
                  rrtr_pkg::OP_ADD: begin
                     if (scan_hit) begin
                        status_in = rrtr_pkg::ST_DUP;
                     end else if (!free_any) begin
                        status_in = rrtr_pkg::ST_FULL;
                     end else begin
                        slot_in  = free_now;
                        state_in = (held_ff == '0) ? S_ADD_WS : S_ADD_RD;
                     end
                  end
                  rrtr_pkg::OP_RETURN: begin
                     if (!scan_hit) begin
                        status_in = rrtr_pkg::ST_NOT_FOUND;
                     end else if (taken_ff[idx_ff]) begin
                        taken_in[idx_ff] = 1'b0;
                        untaken_in       = untaken_ff + CNT_W'(1);
                     end
                  end
                  rrtr_pkg::OP_REMOVE: begin
                     if (!scan_hit) begin
                        status_in = rrtr_pkg::ST_NOT_FOUND;
                     end else begin
                        slot_in  = idx_ff;
                        state_in = S_REM_RD;
                     end
                  end
                  default: begin
                     status_in = rrtr_pkg::ST_NONE;
                  end
               endcase
            end
         end

         // get next: walk the ring from current
         S_GET_RD: begin
            id_raddr  = walk_ff;
            lnk_raddr = walk_ff;
            state_in  = S_GET_STEP;
         end

         S_GET_STEP: begin
            if (valid_ff[walk_ff] && !taken_ff[walk_ff]) begin
               taken_in[walk_ff] = 1'b1;
               untaken_in        = untaken_ff - CNT_W'(1);
               cur_in            = lnk_rdata.link_next;
               granted_in        = 8'(id_rdata);
               status_in         = rrtr_pkg::ST_OK;
               state_in          = S_RESP;
            end else if ((step_ff + CNT_W'(1)) >= held_ff) begin
               status_in = rrtr_pkg::ST_NONE;
               state_in  = S_RESP;
            end else begin
               walk_in   = lnk_rdata.link_next;
               id_raddr  = lnk_rdata.link_next;
               lnk_raddr = lnk_rdata.link_next;
               step_in   = step_ff + CNT_W'(1);
            end
         end

         // add: read links of current and its predecessor
         S_ADD_RD: begin
            lnk_raddr = cur_ff;
            state_in  = S_ADD_P;
         end

         S_ADD_P: begin
            lnk_a_in  = lnk_rdata;
            lnk_raddr = lnk_rdata.link_prev;
            state_in  = S_ADD_WS;
         end

         // write the new entry
         S_ADD_WS: begin
            lnk_b_in = lnk_rdata;
            id_we    = 1'b1;
            lnk_we   = 1'b1;
            lnk_waddr = slot_ff;
            if (held_ff == '0) begin
               lnk_wdata.link_next = slot_ff;
               lnk_wdata.link_prev = slot_ff;
               state_in            = S_ADD_WC;
            end else begin
               lnk_wdata.link_next = cur_ff;
               lnk_wdata.link_prev = lnk_a_ff.link_prev;
               state_in            = S_ADD_WP;
            end
         end

         // predecessor now points at the new entry
         S_ADD_WP: begin
            lnk_we              = 1'b1;
            lnk_waddr           = lnk_a_ff.link_prev;
            lnk_wdata.link_next = slot_ff;
            lnk_wdata.link_prev = lnk_b_ff.link_prev;
            state_in            = S_ADD_WC;
         end

         // current points back at the new entry; forward when it was alone
         S_ADD_WC: begin
            lnk_we              = (held_ff != '0);
            lnk_waddr           = cur_ff;
            lnk_wdata.link_next = (lnk_a_ff.link_prev == cur_ff) ? slot_ff
                                                                  : lnk_a_ff.link_next;
            lnk_wdata.link_prev = slot_ff;
            valid_in[slot_ff]   = 1'b1;
            taken_in[slot_ff]   = 1'b0;
            cur_in              = slot_ff;
            held_in             = held_ff + CNT_W'(1);
            untaken_in          = untaken_ff + CNT_W'(1);
            status_in           = rrtr_pkg::ST_OK;
            state_in            = S_RESP;
         end

         // remove: read the entry and both neighbors
         S_REM_RD: begin
            lnk_raddr = slot_ff;
            state_in  = S_REM_PV;
         end

         S_REM_PV: begin
            lnk_a_in  = lnk_rdata;
            lnk_raddr = lnk_rdata.link_prev;
            state_in  = S_REM_NX;
         end

         S_REM_NX: begin
            lnk_b_in  = lnk_rdata;
            lnk_raddr = lnk_a_ff.link_next;
            state_in  = S_REM_WP;
         end

         S_REM_WP: begin
            lnk_c_in            = lnk_rdata;
            lnk_we              = 1'b1;
            lnk_waddr           = lnk_a_ff.link_prev;
            lnk_wdata.link_next = lnk_a_ff.link_next;
            lnk_wdata.link_prev = lnk_b_ff.link_prev;
            state_in            = S_REM_WN;
         end

         // successor points back; forward when both neighbors are one entry
         S_REM_WN: begin
            lnk_we              = 1'b1;
            lnk_waddr           = lnk_a_ff.link_next;
            lnk_wdata.link_next = (lnk_a_ff.link_next == lnk_a_ff.link_prev)
                                  ? lnk_a_ff.link_next : lnk_c_ff.link_next;
            lnk_wdata.link_prev = lnk_a_ff.link_prev;
            valid_in[slot_ff]   = 1'b0;
            taken_in[slot_ff]   = 1'b0;
            if (!taken_ff[slot_ff] && untaken_ff != '0) begin
               untaken_in = untaken_ff - CNT_W'(1);
            end
            held_in = held_ff - CNT_W'(1);
            if (held_ff == CNT_W'(1)) begin
               cur_in = '0;
            end else if (slot_ff == cur_ff) begin
               cur_in = lnk_a_ff.link_next;
            end
            status_in = rrtr_pkg::ST_OK;
            state_in  = S_RESP;
         end

         // hand the result to the output register
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
      rsp_item_in  = rsp_item_ff;
      if (rsp_load) begin
         rsp_item_in.status         = status_ff;
         rsp_item_in.granted_id     = granted_ff;
         rsp_item_in.occupied_count = 5'(held_ff);
         rsp_item_in.free_count     = 5'(untaken_ff);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         taken_ff     <= '0;
         cur_ff       <= '0;
         held_ff      <= '0;
         untaken_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         taken_ff     <= taken_in;
         cur_ff       <= cur_in;
         held_ff      <= held_in;
         untaken_ff   <= untaken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      type_ff      <= type_in;
      id_ff        <= id_in;
      slot_ff      <= slot_in;
      scan_ff      <= scan_in;
      chk_ff       <= chk_in;
      idx_ff       <= idx_in;
      free_seen_ff <= free_seen_in;
      free_ff      <= free_in;
      walk_ff      <= walk_in;
      step_ff      <= step_in;
      lnk_a_ff     <= lnk_a_in;
      lnk_b_ff     <= lnk_b_in;
      lnk_c_ff     <= lnk_c_in;
      status_ff    <= status_in;
      granted_ff   <= granted_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // held count tracks the valid marks
   a_held_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(held_ff))
      else $error("held count differs from number of valid slots");

   // free count tracks valid entries not taken
   a_free_matches_marks: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff & ~taken_ff) == int'(untaken_ff))
      else $error("free count differs from valid untaken slots");

   // only held entries can be taken
   a_taken_only_valid: assert property (@(posedge clock) disable iff (reset)
      (taken_ff & ~valid_ff) == '0)
      else $error("taken mark on a slot that holds no entry");

   // a new item is only taken with the sequencer idle and leaves it next cycle
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("accepted item did not start the sequencer");

endmodule
